// ===== sv/tibf_pkg.sv =====
// Shared types and constants of the tape image block framer.
`default_nettype none

package tibf_pkg;

   // Marker bytes of the tape format
   localparam logic [7:0] MARK_BYTE    = 8'hA5;
   localparam logic [7:0] QUOTE_BYTE   = 8'h22;
   localparam logic [7:0] TYPE_A_BYTE  = 8'h41;
   localparam logic [7:0] TYPE_B_BYTE  = 8'h42;
   localparam logic [7:0] TYPE_M_BYTE  = 8'h4D;

   // Sync run length after reset
   localparam logic [9:0] SYNC_RESET   = 10'd555;

   // Block type codes
   localparam logic [1:0] BTYPE_A = 2'd0;
   localparam logic [1:0] BTYPE_B = 2'd1;
   localparam logic [1:0] BTYPE_M = 2'd2;

   // Header and trailer byte count added to the length field, per type
   localparam logic [4:0] EXTRA_A = 5'd17;
   localparam logic [4:0] EXTRA_B = 5'd6;
   localparam logic [4:0] EXTRA_M = 5'd10;

   // Position of the low length byte in a block, per type
   localparam logic [16:0] LOWPOS_A  = 17'd3;
   localparam logic [16:0] LOWPOS_BM = 17'd1;

   // One run: byte value, repeat count and dropped-type flag
   typedef struct packed {
      logic [7:0] tape_byte;
      logic [9:0] repeat_count;
      logic       bad_type;
   } run_type;

   // All runs caused by one image byte
   typedef struct packed {
      run_type [2:0] runs;
      logic [1:0]    count;
      logic          end_of_tape;
   } bundle_type;

endpackage

`default_nettype wire

// ===== sv/tibf_parser.sv =====
// Parse state machine: turns one image byte into a bundle of up to three runs.
`default_nettype none

module tibf_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [9:0]           csr_write_data,
   input  wire logic                 take,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 is_last,
   output tibf_pkg::bundle_type      bundle
);

   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_SKIPA5 = 3'd1;
   localparam logic [2:0] PH_NAME   = 3'd2;
   localparam logic [2:0] PH_TYPE   = 3'd3;
   localparam logic [2:0] PH_HEAD   = 3'd4;
   localparam logic [2:0] PH_BODY   = 3'd5;
   localparam logic [2:0] PH_TRAIL  = 3'd6;

   logic [9:0]  sync_length_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  btype_ff, btype_in;
   logic [16:0] index_ff, index_in;
   logic [7:0]  length_low_ff, length_low_in;
   logic [16:0] total_ff, total_in;

   logic [9:0]  sync_eff;
   logic        type_ok;
   logic [1:0]  type_code;
   logic        lead_present;
   tibf_pkg::run_type lead_run;
   tibf_pkg::run_type type_run;
   tibf_pkg::run_type pass_run;
   tibf_pkg::run_type zero_run;
   tibf_pkg::run_type mark_run;
   logic        pass_present;
   logic        sync_present;
   logic        use_lead;
   logic [16:0] lowpos;
   logic [4:0]  extra;
   logic [16:0] index_inc;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_length_ff <= tibf_pkg::SYNC_RESET;
      end else if (csr_write_enable) begin
         sync_length_ff <= csr_write_data;
      end
   end

   assign sync_eff = (sync_length_ff == 10'd0) ? 10'd1 : sync_length_ff;

   // Decode the type letter
   always_comb begin
      type_ok   = 1'b1;
      type_code = tibf_pkg::BTYPE_A;
      unique case (data_byte)
         tibf_pkg::TYPE_A_BYTE: type_code = tibf_pkg::BTYPE_A;
         tibf_pkg::TYPE_B_BYTE: type_code = tibf_pkg::BTYPE_B;
         tibf_pkg::TYPE_M_BYTE: type_code = tibf_pkg::BTYPE_M;
         default:               type_ok   = 1'b0;
      endcase
   end

   // Fixed runs
   always_comb begin
      zero_run          = '0;
      zero_run.repeat_count = sync_eff;
      mark_run          = '0;
      mark_run.tape_byte    = tibf_pkg::MARK_BYTE;
      mark_run.repeat_count = 10'd1;
      pass_run          = '0;
      pass_run.tape_byte    = data_byte;
      pass_run.repeat_count = 10'd1;
      type_run          = '0;
      if (type_ok) begin
         type_run = pass_run;
      end else begin
         type_run.bad_type = 1'b1;
      end
   end

   // Length layout of the current block type
   always_comb begin
      lowpos = (btype_ff == tibf_pkg::BTYPE_A) ? tibf_pkg::LOWPOS_A : tibf_pkg::LOWPOS_BM;
      unique case (btype_ff)
         tibf_pkg::BTYPE_A: extra = tibf_pkg::EXTRA_A;
         tibf_pkg::BTYPE_B: extra = tibf_pkg::EXTRA_B;
         default:           extra = tibf_pkg::EXTRA_M;
      endcase
   end

   assign index_inc = index_ff + 17'd1;

   // Advance the parse state and gather this byte's runs
   always_comb begin
      phase_in      = phase_ff;
      btype_in      = btype_ff;
      index_in      = index_ff;
      length_low_in = length_low_ff;
      total_in      = total_ff;
      pass_present  = 1'b0;
      sync_present  = 1'b0;
      use_lead      = 1'b0;
      lead_present  = 1'b0;
      lead_run      = type_run;

      unique case (phase_ff)
         PH_SKIPA5: use_lead = 1'b1;
         PH_NAME: begin
            pass_present = 1'b1;
            if (data_byte == tibf_pkg::QUOTE_BYTE) begin
               sync_present = 1'b1;
               phase_in     = PH_TYPE;
            end
         end
         PH_TYPE: begin
            lead_present = 1'b1;
            if (type_ok) begin
               btype_in      = type_code;
               index_in      = 17'd1;
               length_low_in = '0;
               total_in      = '0;
               phase_in      = PH_HEAD;
            end else begin
               phase_in = PH_TRAIL;
            end
         end
         PH_HEAD: begin
            pass_present = 1'b1;
            if (index_ff == lowpos) begin
               length_low_in = data_byte;
            end else if (index_ff == lowpos + 17'd1) begin
               total_in = {1'b0, data_byte, length_low_ff} + {12'd0, extra};
               phase_in = PH_BODY;
            end
            index_in = index_inc;
         end
         PH_BODY: begin
            pass_present = 1'b1;
            index_in     = index_inc;
            if (index_inc >= total_ff) begin
               phase_in = PH_TRAIL;
            end
         end
         PH_TRAIL: begin
            if (data_byte != 8'd0) begin
               sync_present = 1'b1;
               use_lead     = 1'b1;
            end
         end
         default: begin
            sync_present = 1'b1;
            use_lead     = 1'b1;
         end
      endcase

      // Byte at a block start: skip a marker, open a name or take the type
      if (use_lead) begin
         if (data_byte == tibf_pkg::MARK_BYTE) begin
            phase_in = PH_SKIPA5;
         end else if (data_byte == tibf_pkg::QUOTE_BYTE) begin
            lead_present = 1'b1;
            lead_run     = pass_run;
            phase_in     = PH_NAME;
         end else begin
            lead_present = 1'b1;
            if (type_ok) begin
               btype_in      = type_code;
               index_in      = 17'd1;
               length_low_in = '0;
               total_in      = '0;
               phase_in      = PH_HEAD;
            end else begin
               phase_in = PH_TRAIL;
            end
         end
      end

      // Image end returns the parser to its start
      if (is_last) begin
         phase_in      = PH_START;
         btype_in      = '0;
         index_in      = '0;
         length_low_in = '0;
         total_in      = '0;
      end
   end

   // Pack the runs in order
   always_comb begin
      bundle             = '0;
      bundle.end_of_tape = is_last;
      if (pass_present) begin
         bundle.runs[0] = pass_run;
         if (sync_present) begin
            bundle.runs[1] = zero_run;
            bundle.runs[2] = mark_run;
            bundle.count   = 2'd3;
         end else begin
            bundle.count = 2'd1;
         end
      end else if (sync_present) begin
         bundle.runs[0] = zero_run;
         bundle.runs[1] = mark_run;
         if (lead_present) begin
            bundle.runs[2] = lead_run;
            bundle.count   = 2'd3;
         end else begin
            bundle.count = 2'd2;
         end
      end else if (lead_present) begin
         bundle.runs[0] = lead_run;
         bundle.count   = 2'd1;
      end else if (is_last) begin
         bundle.count = 2'd1;
      end
   end

   // Hold state between transfers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         btype_ff      <= '0;
         index_ff      <= '0;
         length_low_ff <= '0;
         total_ff      <= '0;
      end else if (take) begin
         phase_ff      <= phase_in;
         btype_ff      <= btype_in;
         index_ff      <= index_in;
         length_low_ff <= length_low_in;
         total_ff      <= total_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/tibf_emitter.sv =====
// Result register: holds one bundle of runs and sends them out one per transfer.
`default_nettype none

module tibf_emitter (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire tibf_pkg::bundle_type bundle,
   output logic                      can_load,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [7:0]                rsp_tape_byte,
   output logic [9:0]                rsp_repeat_count,
   output logic                      rsp_last_of_run,
   output logic                      rsp_end_of_tape,
   output logic                      rsp_bad_type
);

   tibf_pkg::run_type [2:0] runs_ff, runs_in;
   logic [1:0] remain_ff, remain_in;
   logic       end_ff, end_in;
   logic       pop;

   assign pop      = rsp_valid && rsp_ready;
   assign can_load = (remain_ff == 2'd0) || ((remain_ff == 2'd1) && rsp_ready);

   // Load a new bundle, or shift the next run to the front
   always_comb begin
      runs_in   = runs_ff;
      remain_in = remain_ff;
      end_in    = end_ff;
      if (load) begin
         runs_in   = bundle.runs;
         remain_in = bundle.count;
         end_in    = bundle.end_of_tape;
      end else if (pop) begin
         runs_in[0] = runs_ff[1];
         runs_in[1] = runs_ff[2];
         remain_in  = remain_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else begin
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      runs_ff <= runs_in;
      end_ff  <= end_in;
   end

   // Drive the result channel from the front run
   assign rsp_valid        = remain_ff != 2'd0;
   assign rsp_tape_byte    = runs_ff[0].tape_byte;
   assign rsp_repeat_count = runs_ff[0].repeat_count;
   assign rsp_bad_type     = runs_ff[0].bad_type;
   assign rsp_last_of_run  = remain_ff == 2'd1;
   assign rsp_end_of_tape  = (remain_ff == 2'd1) && end_ff;

endmodule

`default_nettype wire

// ===== sv/tape_image_block_framer.sv =====
// Top level of the tape image block framer.
//
// The req_ channel takes one tape image byte per transfer, with req_is_last on
// the final byte. Each byte yields zero to three runs on the rsp_ channel, each
// a byte value and a repeat count: a sync run of zeros and a 0xA5 marker at
// each block start, then the name, header and data bytes passed through.
// rsp_last_of_run marks the final run of a byte, rsp_end_of_tape the final run
// of the image, rsp_bad_type a dropped unknown type letter.
// The first run of a byte is registered and valid in the cycle after its
// transfer. A byte with one or no run is taken every cycle while rsp_ready
// is high; a byte with more runs holds the result register until they go
// out at one run per cycle. A byte is taken while the final run of the
// previous one is being transferred. When the receiver stalls, the runs hold
// and req_ready falls until the last held run goes. csr_write_data sets the
// sync run length (0 acts as 1). Reset empties the result register, sets the
// length to 555 and starts a new image.
`default_nettype none

module tape_image_block_framer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [9:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_is_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_tape_byte,
   output logic [9:0]       rsp_repeat_count,
   output logic             rsp_last_of_run,
   output logic             rsp_end_of_tape,
   output logic             rsp_bad_type
);

   tibf_pkg::bundle_type bundle;
   logic take;
   logic can_load;

   assign req_ready = can_load;
   assign take      = req_valid && can_load;

   tibf_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .take             (take),
      .data_byte        (req_data_byte),
      .is_last          (req_is_last),
      .bundle           (bundle)
   );

   tibf_emitter u_emitter (
      .clock            (clock),
      .reset            (reset),
      .load             (take),
      .bundle           (bundle),
      .can_load         (can_load),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tape_byte    (rsp_tape_byte),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_tape  (rsp_end_of_tape),
      .rsp_bad_type     (rsp_bad_type)
   );

endmodule

`default_nettype wire
